// ===== rtl/gated_smoothing_tracker_assert.svh =====
// Assertion macros for the tracker checker.
// Both expect i_clk and i_rst_n in scope.
`ifndef GATED_SMOOTHING_TRACKER_ASSERT_SVH
`define GATED_SMOOTHING_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define GST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gst check failed");

// Next-cycle implication.
`define GST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gst check failed");

`endif

// ===== rtl/gst_pkg.sv =====
package gst_pkg;

    localparam int unsigned VAL_W      = 24;
    localparam int unsigned SAMPLE_W   = 25;
    localparam int unsigned INNOV_W    = 24;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned WARM_W     = 16;
    localparam int unsigned GAIN_W     = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned QUO_W      = 23;
    localparam int unsigned PROD_W     = 48;
    localparam int unsigned DIV_CNT_W  = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    localparam logic [WARM_W-1:0]  WARMUP_RST   = 16'd10;
    localparam logic [VAL_W-1:0]   MAXINNOV_RST = 24'd3277;
    localparam logic [GAIN_W-1:0]  GAIN_RST     = 17'd6554;
    localparam logic [GAIN_W-1:0]  GAIN_ONE     = 17'd65536;

    localparam logic [INNOV_W-1:0] INNOV_POS_SAT = 24'h7FFFFF;
    localparam logic [INNOV_W-1:0] INNOV_NEG_SAT = 24'h800000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXINNOV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_BAD     = 3'd0,
        ST_JUMP    = 3'd1,
        ST_WARMUP  = 3'd2,
        ST_ACCEPT  = 3'd3,
        ST_RESET   = 3'd4
    } t_status;

    typedef struct packed {
        logic cap_in;
        logic prep;
        logic gate;
        logic div_step;
        logic decide;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic special;
    } t_stat;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (&c) ? c : c + CNT_W'(1);
    endfunction

endpackage

// ===== rtl/gated_smoothing_tracker.sv =====
// channel | direction | handshake                    | word
// --------+-----------+------------------------------+-------------------------------------
// in      | input     | i_in_valid / o_in_ready      | i_action, i_sample_value
// out     | output    | o_out_valid / i_out_ready    | status, accepted flag, tracked value,
//         |           |                              | innovation, convergence, both counts
// cfg     | input     | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// A measurement word goes from accept to result through capture, prepare,
// gate multiply, 23 steps of the radix-2 divider, decide and write back.
// Reset words and words that cannot be tracked skip from prepare to write back.
// One word is in work at a time; the next word is taken while the result
// waits in the output register. A stalled output holds the last step.
// Reset is synchronous and active low; it restores the register defaults.
module gated_smoothing_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gst_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic signed [gst_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_was_accepted,
    output logic [gst_pkg::STATUS_W-1:0]        o_status,
    output logic [gst_pkg::VAL_W-1:0]           o_tracked_value,
    output logic signed [gst_pkg::INNOV_W-1:0]  o_innovation,
    output logic                                o_is_converged,
    output logic [gst_pkg::CNT_W-1:0]           o_accepted_total,
    output logic [gst_pkg::CNT_W-1:0]           o_rejected_total
);
    import gst_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer: walks each word through prepare, divide and decide; special words skip to finish.
    gst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath: tracker state, shared multiplier, divider, result register.
    gst_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_sample_value   (i_sample_value),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_was_accepted   (o_was_accepted),
        .o_status         (o_status),
        .o_tracked_value  (o_tracked_value),
        .o_innovation     (o_innovation),
        .o_is_converged   (o_is_converged),
        .o_accepted_total (o_accepted_total),
        .o_rejected_total (o_rejected_total)
    );

endmodule

// ===== rtl/gst_ctrl.sv =====
module gst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  gst_pkg::t_stat i_stat,
    output gst_pkg::t_cmd  o_cmd
);
    import gst_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_GATE   = 6'b000100,
        S_DIV    = 6'b001000,
        S_DECIDE = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_valid, n_out_valid;
    t_cmd                 w_cmd;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        w_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.cap_in = 1'b1;
                    n_state      = S_PREP;
                end
            end
            S_PREP: begin
                w_cmd.prep = 1'b1;
                n_state    = i_stat.special ? S_FIN : S_GATE;
            end
            S_GATE: begin
                w_cmd.gate = 1'b1;
                n_div_cnt  = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                w_cmd.decide = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// ===== rtl/gst_datapath.sv =====
module gst_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [gst_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [gst_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_action,
    input  logic signed [gst_pkg::SAMPLE_W-1:0]    i_sample_value,
    input  gst_pkg::t_cmd                          i_cmd,
    output gst_pkg::t_stat                         o_stat,
    output logic                                   o_was_accepted,
    output logic [gst_pkg::STATUS_W-1:0]           o_status,
    output logic [gst_pkg::VAL_W-1:0]              o_tracked_value,
    output logic signed [gst_pkg::INNOV_W-1:0]     o_innovation,
    output logic                                   o_is_converged,
    output logic [gst_pkg::CNT_W-1:0]              o_accepted_total,
    output logic [gst_pkg::CNT_W-1:0]              o_rejected_total
);
    import gst_pkg::*;

    // configuration
    logic [WARM_W-1:0]   r_warmup;
    logic [VAL_W-1:0]    r_max_innov;
    logic [GAIN_W-1:0]   r_gain;

    // tracker state
    logic [VAL_W-1:0]    r_tracked, n_tracked;
    logic                r_armed, n_armed;
    logic [CNT_W-1:0]    r_acc_cnt, n_acc_cnt;
    logic [CNT_W-1:0]    r_rej_cnt, n_rej_cnt;

    // item work registers
    logic                r_action;
    logic [SAMPLE_W-1:0] r_sample;
    logic [VAL_W-1:0]    r_mag;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic [VAL_W-1:0]    r_rem;
    logic [QUO_W-1:0]    r_dsh;
    logic [QUO_W-1:0]    r_quo;
    logic                r_ovf;
    logic                r_reject;
    logic                r_warming;

    // result registers
    logic                r_o_acc;
    t_status             r_o_status;
    logic [VAL_W-1:0]    r_o_tracked;
    logic [INNOV_W-1:0]  r_o_innov;
    logic                r_o_conv;
    logic [CNT_W-1:0]    r_o_acc_cnt;
    logic [CNT_W-1:0]    r_o_rej_cnt;

    logic                w_sample_pos;
    logic                w_bad;
    logic [VAL_W+1:0]    w_diff;
    logic [VAL_W+1:0]    w_abs;
    logic [GAIN_W-1:0]   w_gain_cap;
    logic [VAL_W-1:0]    w_mul_a;
    logic [VAL_W-1:0]    w_mul_b;
    logic [PROD_W-1:0]   w_prod;
    logic [VAL_W:0]      w_trial;
    logic                w_qbit;
    logic                w_warming;
    logic                w_jump;
    logic [VAL_W-1:0]    w_step;
    logic [VAL_W-1:0]    w_new_t;
    logic [INNOV_W-1:0]  w_innov;
    logic                w_o_acc;
    t_status             w_o_status;
    logic [INNOV_W-1:0]  w_o_innov;

    always_comb begin
        w_sample_pos = !r_sample[SAMPLE_W-1] && (r_sample[VAL_W-1:0] != '0);
        w_bad        = !r_armed || !w_sample_pos || (r_tracked == '0);
        w_diff       = {r_sample[SAMPLE_W-1], r_sample} - {2'b00, r_tracked};
        w_abs        = w_diff[VAL_W+1] ? ((VAL_W+2)'(0) - w_diff) : w_diff;
    end

    assign o_stat.special = r_action || w_bad;

    // one shared multiplier: gate product first, smoothing step later
    assign w_gain_cap = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
    assign w_mul_a    = i_cmd.gate ? r_max_innov : r_mag;
    assign w_mul_b    = i_cmd.gate ? r_tracked : VAL_W'(w_gain_cap);
    assign w_prod     = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // one restoring division step
    assign w_trial = {r_rem, r_dsh[QUO_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_tracked});

    assign w_warming = (r_acc_cnt < CNT_W'(r_warmup));
    assign w_jump    = (PROD_W'({r_mag, 16'b0}) > r_prod);
    assign w_step    = r_prod[VAL_W+15:16];
    assign w_new_t   = r_neg ? (r_tracked - w_step) : (r_tracked + w_step);

    always_comb begin
        if (r_ovf) begin
            w_innov = r_neg ? INNOV_NEG_SAT : INNOV_POS_SAT;
        end else if (r_neg) begin
            w_innov = INNOV_W'(0) - {1'b0, r_quo};
        end else begin
            w_innov = {1'b0, r_quo};
        end
    end

    // next state and result of the item in flight
    always_comb begin
        n_tracked  = r_tracked;
        n_armed    = r_armed;
        n_acc_cnt  = r_acc_cnt;
        n_rej_cnt  = r_rej_cnt;
        w_o_acc    = 1'b0;
        w_o_status = ST_BAD;
        w_o_innov  = '0;
        if (r_action) begin
            n_tracked  = w_sample_pos ? r_sample[VAL_W-1:0] : '0;
            n_armed    = w_sample_pos;
            n_acc_cnt  = '0;
            n_rej_cnt  = '0;
            w_o_status = ST_RESET;
        end else if (w_bad) begin
            w_o_status = ST_BAD;
        end else if (r_reject) begin
            n_rej_cnt  = sat_inc(r_rej_cnt);
            w_o_status = ST_JUMP;
            w_o_innov  = w_innov;
        end else begin
            n_tracked  = w_new_t;
            n_acc_cnt  = sat_inc(r_acc_cnt);
            w_o_acc    = 1'b1;
            w_o_status = r_warming ? ST_WARMUP : ST_ACCEPT;
            w_o_innov  = w_innov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup    <= WARMUP_RST;
            r_max_innov <= MAXINNOV_RST;
            r_gain      <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WARMUP:   r_warmup    <= i_cfg_data[WARM_W-1:0];
                CFG_MAXINNOV: r_max_innov <= i_cfg_data[VAL_W-1:0];
                CFG_GAIN:     r_gain      <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked <= '0;
            r_armed   <= 1'b0;
            r_acc_cnt <= '0;
            r_rej_cnt <= '0;
        end else if (i_cmd.finish) begin
            r_tracked <= n_tracked;
            r_armed   <= n_armed;
            r_acc_cnt <= n_acc_cnt;
            r_rej_cnt <= n_rej_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_action <= i_action;
            r_sample <= i_sample_value;
        end
        if (i_cmd.prep) begin
            r_mag <= w_abs[VAL_W-1:0];
            r_neg <= w_diff[VAL_W+1];
        end
        if (i_cmd.gate) begin
            r_prod <= w_prod;
            r_rem  <= VAL_W'(r_mag[VAL_W-1:7]);
            r_dsh  <= {r_mag[6:0], 16'b0};
            r_ovf  <= (VAL_W'(r_mag[VAL_W-1:7]) >= r_tracked);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_qbit ? VAL_W'(w_trial - {1'b0, r_tracked}) : w_trial[VAL_W-1:0];
            r_dsh <= {r_dsh[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_qbit};
        end
        if (i_cmd.decide) begin
            r_warming <= w_warming;
            r_reject  <= !w_warming && w_jump;
            r_prod    <= w_prod;
        end
        if (i_cmd.finish) begin
            r_o_acc     <= w_o_acc;
            r_o_status  <= w_o_status;
            r_o_tracked <= n_tracked;
            r_o_innov   <= w_o_innov;
            r_o_conv    <= n_armed && (n_acc_cnt >= CNT_W'(r_warmup));
            r_o_acc_cnt <= n_acc_cnt;
            r_o_rej_cnt <= n_rej_cnt;
        end
    end

    assign o_was_accepted   = r_o_acc;
    assign o_status         = r_o_status;
    assign o_tracked_value  = r_o_tracked;
    assign o_innovation     = r_o_innov;
    assign o_is_converged   = r_o_conv;
    assign o_accepted_total = r_o_acc_cnt;
    assign o_rejected_total = r_o_rej_cnt;

endmodule

// ===== rtl/gst_checker.sv =====
`include "gated_smoothing_tracker_assert.svh"

module gst_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic                                o_was_accepted,
    input logic [gst_pkg::STATUS_W-1:0]        o_status,
    input logic [gst_pkg::VAL_W-1:0]           o_tracked_value,
    input logic signed [gst_pkg::INNOV_W-1:0]  o_innovation,
    input logic [gst_pkg::CNT_W-1:0]           o_accepted_total,
    input logic [gst_pkg::CNT_W-1:0]           o_rejected_total
);
    import gst_pkg::*;

    // a reset word clears both counts and carries no innovation
    `GST_ASSERT_NOW(a_reset_clears, o_out_valid && (o_status == ST_RESET), (o_accepted_total == '0) && (o_rejected_total == '0) && !o_was_accepted && (o_innovation == '0))

    // absorbed flag agrees with the status code
    `GST_ASSERT_NOW(a_acc_matches_status, o_out_valid, o_was_accepted == ((o_status == ST_WARMUP) || (o_status == ST_ACCEPT)))

    // an untracked word reports no innovation
    `GST_ASSERT_NOW(a_bad_no_innov, o_out_valid && (o_status == ST_BAD), (o_innovation == '0) && !o_was_accepted)

    // one word in work at a time
    `GST_ASSERT_NEXT(a_busy_after_take, i_in_valid && o_in_ready, !o_in_ready)

    // a stalled result holds
    `GST_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_tracked_value))

endmodule

bind gated_smoothing_tracker gst_checker u_gst_checker (.*);

// ===== verif/tb_gated_smoothing_tracker.sv =====
`timescale 1ns / 1ps

module tb_gated_smoothing_tracker;

    import gst_pkg::*;

    // Word kinds on the input channel; the package has no names for these.
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_RESET  = 1'b1;

    // Index past the end of the register list; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int SETTLE      = 60;    // idle cycles after the last result before the verdict
    localparam int SEG_WORDS   = 95;    // random words per configuration segment

    typedef struct packed {
        logic               was_accepted;
        t_status            status;
        logic [VAL_W-1:0]   tracked;
        logic [INNOV_W-1:0] innov;
        logic               converged;
        logic [CNT_W-1:0]   acc_total;
        logic [CNT_W-1:0]   rej_total;
    } t_track_word;

    typedef enum {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic                    act;
        logic [SAMPLE_W-1:0]     smp;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        bit                      known;
        t_track_word             want;
    } t_stim_row;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       action = ACT_UPDATE;
    logic signed [SAMPLE_W-1:0] sample_value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       out_was_accepted;
    logic [STATUS_W-1:0]        out_status;
    logic [VAL_W-1:0]           out_tracked;
    logic signed [INNOV_W-1:0]  out_innov;
    logic                       out_converged;
    logic [CNT_W-1:0]           out_acc_total;
    logic [CNT_W-1:0]           out_rej_total;

    // Tracker mirror: configuration and state as the block should hold them.
    logic [WARM_W-1:0]  cfg_warm;
    logic [VAL_W-1:0]   cfg_maxinn;
    logic [GAIN_W-1:0]  cfg_gain;
    logic [VAL_W-1:0]   trk_val;
    logic               trk_armed;
    logic [CNT_W-1:0]   acc_cnt;
    logic [CNT_W-1:0]   rej_cnt;

    t_track_word predicted_q[$];
    t_stim_row   dir_rows[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_cnt = 0;
    int quiet_cycles = 0;

    gated_smoothing_tracker DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_action         (action),
        .i_sample_value   (sample_value),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_was_accepted   (out_was_accepted),
        .o_status         (out_status),
        .o_tracked_value  (out_tracked),
        .o_innovation     (out_innov),
        .o_is_converged   (out_converged),
        .o_accepted_total (out_acc_total),
        .o_rejected_total (out_rej_total)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Tracker mirror
    // ------------------------------------------------------------------

    function automatic void mirror_reset();
        cfg_warm   = WARMUP_RST;
        cfg_maxinn = MAXINNOV_RST;
        cfg_gain   = GAIN_RST;
        trk_val    = '0;
        trk_armed  = 1'b0;
        acc_cnt    = '0;
        rej_cnt    = '0;
    endfunction

    // Apply a register write the way the block masks it.
    function automatic void mirror_config(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WARMUP:   cfg_warm   = data[WARM_W-1:0];
            CFG_MAXINNOV: cfg_maxinn = data[VAL_W-1:0];
            CFG_GAIN:     cfg_gain   = data[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    // Build a result word from the current mirror state.
    function automatic t_track_word form_word(input logic acc, input t_status st,
                                              input logic [INNOV_W-1:0] inn);
        t_track_word w;
        w.was_accepted = acc;
        w.status       = st;
        w.tracked      = trk_val;
        w.innov        = inn;
        w.converged    = trk_armed && (acc_cnt >= CNT_W'(cfg_warm));
        w.acc_total    = acc_cnt;
        w.rej_total    = rej_cnt;
        return w;
    endfunction

    // Advance the mirror by one input word and return the result it causes.
    function automatic t_track_word track_step(input logic act,
                                               input logic signed [SAMPLE_W-1:0] smp);
        longint          m;
        longint          diff;
        longint          q;
        longint          nt;
        longint unsigned mag;
        longint unsigned tu;
        longint unsigned step;
        logic [GAIN_W-1:0] g;
        logic            warming;
        m = smp;
        if (act == ACT_RESET) begin
            if (m > 0) begin
                trk_val   = smp[VAL_W-1:0];
                trk_armed = 1'b1;
            end else begin
                trk_val   = '0;
                trk_armed = 1'b0;
            end
            acc_cnt = '0;
            rej_cnt = '0;
            return form_word(1'b0, ST_RESET, '0);
        end
        // Unarmed, non-positive sample, or a zero track: nothing to compute.
        if (!trk_armed || m <= 0 || trk_val == '0)
            return form_word(1'b0, ST_BAD, '0);

        tu   = 64'(trk_val);
        diff = m - longint'(tu);
        mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
        q    = longint'((mag << 16) / tu);
        if (diff < 0)
            q = -q;
        if (q > 64'sd8388607)
            q = 64'sd8388607;
        if (q < -64'sd8388608)
            q = -64'sd8388608;

        // Gate on the exact quotient, not on the truncated field.
        warming = acc_cnt < CNT_W'(cfg_warm);
        if (!warming && (mag << 16) > 64'(cfg_maxinn) * tu) begin
            rej_cnt = count_up(rej_cnt);
            return form_word(1'b0, ST_JUMP, q[INNOV_W-1:0]);
        end

        // Clamp the gain at one so the track never overshoots.
        g    = (cfg_gain > GAIN_ONE) ? GAIN_ONE : cfg_gain;
        step = (mag * 64'(g)) >> 16;
        nt   = (diff < 0) ? longint'(tu) - longint'(step) : longint'(tu) + longint'(step);
        trk_val = nt[VAL_W-1:0];
        acc_cnt = count_up(acc_cnt);
        return form_word(1'b1, warming ? ST_WARMUP : ST_ACCEPT, q[INNOV_W-1:0]);
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------

    function automatic t_track_word mk_word(input logic acc, input t_status st,
                                            input logic [VAL_W-1:0] trk,
                                            input logic [INNOV_W-1:0] inn, input logic conv,
                                            input logic [CNT_W-1:0] at,
                                            input logic [CNT_W-1:0] rt);
        t_track_word w;
        w = '{acc, st, trk, inn, conv, at, rt};
        return w;
    endfunction

    function automatic t_stim_row word_row(input logic act, input logic [SAMPLE_W-1:0] smp);
        t_stim_row r;
        r = '{ROW_WORD, act, smp, '0, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_stim_row known_row(input logic act, input logic [SAMPLE_W-1:0] smp,
                                            input t_track_word want);
        t_stim_row r;
        r = '{ROW_WORD, act, smp, '0, '0, 1'b1, want};
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = '{ROW_CFG, ACT_UPDATE, '0, idx, data, 1'b0, '0};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one word, hold it until accepted, then log its expected result.
    // Returns at the accepting edge with valid still high.
    task automatic send_word(input logic act, input logic [SAMPLE_W-1:0] smp,
                             input bit known, input t_track_word typed);
        t_track_word pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        sample_value <= smp;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        pred = track_step(act, smp);
        predicted_q.push_back(known ? typed : pred);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (predicted_q.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; enable goes low again before return so it never falls and rises in one step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        mirror_config(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Pick a settings mix per segment; extremes come round every phase.
    task automatic configure_segment(input int sel);
        case (sel)
            0: begin
                cfg_write(CFG_WARMUP,   24'($urandom_range(0, 20)));
                cfg_write(CFG_MAXINNOV, 24'($urandom_range(1000, 20000)));
                cfg_write(CFG_GAIN,     24'($urandom_range(1, 65535)));
            end
            1: begin
                cfg_write(CFG_WARMUP,   '0);
                cfg_write(CFG_MAXINNOV, 24'($urandom_range(0, 70000)));
                cfg_write(CFG_GAIN,     24'($urandom_range(0, 65536)));
            end
            2: begin
                cfg_write(CFG_WARMUP,   '0);
                cfg_write(CFG_MAXINNOV, '0);
                cfg_write(CFG_GAIN,     24'(GAIN_ONE));
            end
            3: begin
                cfg_write(CFG_WARMUP,   24'hFFFF);
                cfg_write(CFG_MAXINNOV, 24'hFFFFFF);
                cfg_write(CFG_GAIN,     '0);
            end
            4: begin
                cfg_write(CFG_WARMUP,   24'($urandom_range(0, 5)));
                cfg_write(CFG_MAXINNOV, 24'($urandom()));
                cfg_write(CFG_GAIN,     24'hFFFFFF);
            end
            default: begin
                cfg_write(CFG_WARMUP,   24'($urandom()));
                cfg_write(CFG_MAXINNOV, 24'($urandom()));
                cfg_write(CFG_GAIN,     24'($urandom()));
            end
        endcase
        cfg_write(CFG_UNUSED, 24'($urandom()));
    endtask

    // Positive Q16.8 value with a random bit length, so small and large both show.
    function automatic logic [SAMPLE_W-1:0] pick_value();
        int sh;
        logic [VAL_W-1:0] v;
        sh = $urandom_range(0, 23);
        v  = VAL_W'($urandom()) >> (23 - sh);
        if (v == '0)
            v = VAL_W'(1);
        return {1'b0, v};
    endfunction

    // Mostly well-formed tracks: a reset, then measurements near the track.
    task automatic run_segment(input int n);
        int              r;
        int              k;
        longint          span;
        longint          m;
        logic [SAMPLE_W-1:0] smp;
        logic            act;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (!trk_armed || r < 6) begin
                act = ACT_RESET;
                if ($urandom_range(0, 99) < 80)
                    smp = pick_value();
                else if ($urandom_range(0, 1) == 0)
                    smp = '0;
                else
                    smp = SAMPLE_W'($urandom()) | 25'h1000000;
            end else if (r < 12) begin
                // Noise: any bit pattern, zero and negative included.
                act = ACT_UPDATE;
                smp = SAMPLE_W'($urandom());
            end else if (r < 16) begin
                act = ACT_UPDATE;
                smp = {1'b0, trk_val};
            end else begin
                act  = ACT_UPDATE;
                k    = ($urandom_range(0, 99) < 80) ? $urandom_range(4, 12)
                                                    : $urandom_range(0, 3);
                span = longint'(trk_val >> k) + 1;
                m    = longint'(trk_val) + longint'($urandom_range(0, 32'(2 * span))) - span;
                if (m < 1)
                    m = 1;
                if (m > 64'd16777215)
                    m = 64'd16777215;
                smp = m[SAMPLE_W-1:0];
            end
            send_word(act, smp, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, compare each result word in order
    // ------------------------------------------------------------------

    always @(posedge clk) begin : result_side
        t_track_word want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (predicted_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result word: status %0d tracked %h",
                             out_status, out_tracked);
            end else begin
                want = predicted_q.pop_front();
                if (out_was_accepted !== want.was_accepted || out_status !== want.status ||
                    out_tracked !== want.tracked || out_innov !== want.innov ||
                    out_converged !== want.converged || out_acc_total !== want.acc_total ||
                    out_rej_total !== want.rej_total) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch exp: acc %0d st %0d trk %h inn %h conv %0d %0d/%0d",
                                 want.was_accepted, want.status, want.tracked, want.innov,
                                 want.converged, want.acc_total, want.rej_total);
                        $display("         got: acc %0d st %0d trk %h inn %h conv %0d %0d/%0d",
                                 out_was_accepted, out_status, out_tracked, out_innov,
                                 out_converged, out_acc_total, out_rej_total);
                    end
                end
            end
        end
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        // Count cycles with no handshake on either channel.
        if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: stop a hung run.
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        t_stim_row row;

        // Directed part, default registers first.
        // Update before any reset word: nothing armed.
        dir_rows.push_back(known_row(ACT_UPDATE, 25'd100,
                                     mk_word(1'b0, ST_BAD, '0, '0, 1'b0, '0, '0)));
        // Reset with zero and with the most negative sample: unarmed.
        dir_rows.push_back(known_row(ACT_RESET, 25'd0,
                                     mk_word(1'b0, ST_RESET, '0, '0, 1'b0, '0, '0)));
        dir_rows.push_back(known_row(ACT_RESET, 25'h1000000,
                                     mk_word(1'b0, ST_RESET, '0, '0, 1'b0, '0, '0)));
        dir_rows.push_back(known_row(ACT_UPDATE, 25'd5000,
                                     mk_word(1'b0, ST_BAD, '0, '0, 1'b0, '0, '0)));
        // Largest positive initial value arms the tracker.
        dir_rows.push_back(known_row(ACT_RESET, 25'hFFFFFF,
                                     mk_word(1'b0, ST_RESET, 24'hFFFFFF, '0, 1'b0, '0, '0)));
        // Zero and minus one samples are bad, state held.
        dir_rows.push_back(known_row(ACT_UPDATE, 25'd0,
                                     mk_word(1'b0, ST_BAD, 24'hFFFFFF, '0, 1'b0, '0, '0)));
        dir_rows.push_back(known_row(ACT_UPDATE, 25'h1FFFFFF,
                                     mk_word(1'b0, ST_BAD, 24'hFFFFFF, '0, 1'b0, '0, '0)));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'd1));
        dir_rows.push_back(known_row(ACT_RESET, 25'd1,
                                     mk_word(1'b0, ST_RESET, 24'd1, '0, 1'b0, '0, '0)));
        // Huge jump off a tiny track saturates the innovation high.
        dir_rows.push_back(word_row(ACT_UPDATE, 25'hFFFFFF));
        // Gate active at once, zero tolerance, full gain.
        dir_rows.push_back(cfg_row(CFG_WARMUP, '0));
        dir_rows.push_back(cfg_row(CFG_MAXINNOV, '0));
        dir_rows.push_back(cfg_row(CFG_GAIN, 24'(GAIN_ONE)));
        dir_rows.push_back(known_row(ACT_RESET, 25'd25600,
                                     mk_word(1'b0, ST_RESET, 24'd25600, '0, 1'b1, '0, '0)));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'd25600));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'd25601));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'd25599));
        // Widest tolerance: full gain jumps straight to the sample.
        dir_rows.push_back(cfg_row(CFG_MAXINNOV, 24'hFFFFFF));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'hFFFFFF));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'd1));
        // Gain above one, written through the full data width, acts as one.
        dir_rows.push_back(cfg_row(CFG_GAIN, 24'hFFFFFF));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'd30000));
        // Write past the register list: must change nothing.
        dir_rows.push_back(cfg_row(CFG_UNUSED, 24'h5A5A5A));
        dir_rows.push_back(cfg_row(CFG_WARMUP, 24'hFFFF));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'd30001));
        // Exact-quotient gate: track 3, step 1 gives a truncated field equal to
        // the limit, yet the exact ratio is just over it.
        dir_rows.push_back(cfg_row(CFG_WARMUP, '0));
        dir_rows.push_back(cfg_row(CFG_MAXINNOV, 24'd21845));
        dir_rows.push_back(word_row(ACT_RESET, 25'd3));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'd4));
        dir_rows.push_back(word_row(ACT_UPDATE, 25'd2));

        // Hold reset, then release at an edge.
        mirror_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 51;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                cfg_write(row.idx, row.data);
            end else begin
                send_word(row.act, row.smp, row.known, row.want);
            end
        end

        // Random part: three back-pressure mixes, six register settings each.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 7;  recv_idle_pct = 51; end
                1: begin send_idle_pct = 51; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int seg = 0; seg < 6; seg++) begin
                wait_idle();
                configure_segment(seg);
                run_segment(SEG_WORDS);
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (err_cnt == 0 && predicted_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gst_pkg.sv
rtl/gst_ctrl.sv
rtl/gst_datapath.sv
rtl/gated_smoothing_tracker.sv
rtl/gst_checker.sv
verif/tb_gated_smoothing_tracker.sv
